### sv/ptf_pkg.sv
// ----------------------------------------------------------------------------
// ptf_pkg
// Shared types and constants of the telemetry packet framer.
// ----------------------------------------------------------------------------
package ptf_pkg;

   localparam int TIME_BYTES  = 4;
   localparam int HDR_BYTES   = 9 + TIME_BYTES;
   localparam int FIT_EXTRA   = 11 + TIME_BYTES;
   localparam int CODED_EXTRA = 5 + TIME_BYTES;
   localparam int CLOSE_BEATS = 3;
   localparam int MAX_RESULTS = 16;
   localparam int BEAT_W      = $clog2(MAX_RESULTS);
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
   localparam int QDEPTH      = 4;
   localparam int QPTR_W      = $clog2(QDEPTH);
   localparam int QCNT_W      = $clog2(QDEPTH + 1);

   localparam logic [7:0] SEQ_WRAP     = 8'hFF;
   localparam logic [7:0] SEQ_BASE     = 8'hC0;
   localparam logic [7:0] VERSION_BYTE = 8'h10;

   localparam logic [1:0] FUNC_RESET = 2'd0;
   localparam logic [1:0] FUNC_START = 2'd1;
   localparam logic [1:0] FUNC_DATA  = 2'd2;

   typedef enum logic [1:0] {
      CMD_RESET,
      CMD_OVERFLOW,
      CMD_HEADER,
      CMD_DATA
   } cmd_kind_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [15:0] data_length;
      logic [7:0]  packet_type;
      logic [7:0]  packet_subtype;
      logic [31:0] time_tag;
      logic [7:0]  payload_byte;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] write_address;
      logic [7:0]  write_byte;
      logic        write_valid;
      logic        overflow;
      logic        last;
   } rsp_payload_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [15:0]  addr;
      logic         close;
      logic [7:0]   count;
      logic [7:0]   seq;
      logic [15:0]  coded;
      logic [7:0]   ptype;
      logic [7:0]   psub;
      logic [31:0]  ttag;
      logic [7:0]   pbyte;
   } cmd_type;

endpackage

### sv/pus_telemetry_packet_framer.sv
// ----------------------------------------------------------------------------
// pus_telemetry_packet_framer
// Frames telemetry packets into byte writes of a telemetry buffer: packet
// count at address 0, headers and payload from address 1 on.
//
//   channel  ports                         direction  transfer
//   req      req_valid/req_stall/req_payload  in       one item
//   rsp      rsp_valid/rsp_stall/rsp_payload  out      one buffer write
//   csr      psel/penable/pwrite/paddr/...    in/out   register access
//
// An item is taken every cycle while the command queue has room.
// Results leave the back part one per cycle while rsp_stall is low: a payload
// byte gives one result, a last payload byte four, a header 13 (16 for an
// empty packet). An item's first result passes the command queue, then the
// output register. rsp_stall holds the output register; the four-entry queue
// keeps taking items until it fills, then req_stall rises.
// reset is synchronous; it restores the registers and framing state.
// ----------------------------------------------------------------------------
module pus_telemetry_packet_framer import ptf_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,
   input  logic            psel,
   input  logic            penable,
   input  logic            pwrite,
   input  logic [2:0]      paddr,
   input  logic [31:0]     pwdata,
   output logic [31:0]     prdata,
   output logic            pready
);

   localparam logic REG_CAPACITY  = 1'b0;
   localparam logic REG_PACKET_ID = 1'b1;

   logic [15:0] capacity_ff, capacity_in;
   logic [15:0] packet_id_ff, packet_id_in;
   logic        cfg_write;

   logic    accept;
   logic    push;
   cmd_type push_cmd;
   logic    pop;
   logic    head_valid;
   cmd_type head_cmd;
   logic    full;

   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;
   assign prdata    = (paddr[2] == REG_PACKET_ID) ? {16'b0, packet_id_ff}
                                                  : {16'b0, capacity_ff};

   always_comb begin
      capacity_in  = capacity_ff;
      packet_id_in = packet_id_ff;
      if (cfg_write) begin
         unique case (paddr[2])
            REG_CAPACITY:  capacity_in  = pwdata[15:0];
            REG_PACKET_ID: packet_id_in = pwdata[15:0];
            default:       capacity_in  = capacity_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= 16'd1024;
         packet_id_ff <= '0;
      end else begin
         capacity_ff  <= capacity_in;
         packet_id_ff <= packet_id_in;
      end
   end

   assign req_stall = full;
   assign accept    = req_valid && !full;

   ptf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_payload (req_payload),
      .capacity    (capacity_ff),
      .push        (push),
      .cmd         (push_cmd)
   );

   ptf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .full       (full)
   );

   ptf_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_cmd    (head_cmd),
      .packet_id   (packet_id_ff),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

### sv/ptf_front.sv
// ----------------------------------------------------------------------------
// ptf_front
// Accepts input items, keeps the framing state and issues one write command
// per item that causes results.
// ----------------------------------------------------------------------------
module ptf_front import ptf_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  req_payload_type req_payload,
   input  logic [15:0]     capacity,
   output logic            push,
   output cmd_type         cmd
);

   logic [15:0] wp_ff, wp_in;
   logic [7:0]  seq_ff, seq_in;
   logic [7:0]  count_ff, count_in;
   logic [15:0] rem_ff, rem_in;
   logic        open_ff, open_in;

   logic [7:0]  seq_next;
   logic [7:0]  count_next;
   logic [17:0] need;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         seq_ff   <= SEQ_BASE;
         count_ff <= '0;
         rem_ff   <= '0;
         open_ff  <= 1'b0;
      end else begin
         wp_ff    <= wp_in;
         seq_ff   <= seq_in;
         count_ff <= count_in;
         rem_ff   <= rem_in;
         open_ff  <= open_in;
      end
   end

   always_comb begin
      seq_next   = (seq_ff == SEQ_WRAP) ? SEQ_BASE : seq_ff + 8'd1;
      count_next = count_ff + 8'd1;
      need       = {2'b00, wp_ff} + {2'b00, req_payload.data_length} + 18'(FIT_EXTRA);

      wp_in    = wp_ff;
      seq_in   = seq_ff;
      count_in = count_ff;
      rem_in   = rem_ff;
      open_in  = open_ff;
      push     = 1'b0;

      cmd.kind  = CMD_RESET;
      cmd.addr  = wp_ff;
      cmd.close = 1'b0;
      cmd.count = count_next;
      cmd.seq   = seq_next;
      cmd.coded = req_payload.data_length + 16'(CODED_EXTRA);
      cmd.ptype = req_payload.packet_type;
      cmd.psub  = req_payload.packet_subtype;
      cmd.ttag  = req_payload.time_tag;
      cmd.pbyte = req_payload.payload_byte;

      if (accept) begin
         unique case (req_payload.func)
            FUNC_RESET: begin
               wp_in    = 16'd1;
               count_in = '0;
               rem_in   = '0;
               open_in  = 1'b0;
               push     = 1'b1;
               cmd.kind = CMD_RESET;
            end
            FUNC_START: begin
               seq_in  = seq_next;
               rem_in  = '0;
               open_in = 1'b0;
               push    = 1'b1;
               if (need > {2'b00, capacity}) begin
                  cmd.kind = CMD_OVERFLOW;
               end else begin
                  cmd.kind = CMD_HEADER;
                  if (req_payload.data_length == '0) begin
                     cmd.close = 1'b1;
                     wp_in     = wp_ff + 16'(HDR_BYTES + 2);
                     count_in  = count_next;
                  end else begin
                     wp_in   = wp_ff + 16'(HDR_BYTES);
                     rem_in  = req_payload.data_length;
                     open_in = 1'b1;
                  end
               end
            end
            FUNC_DATA: begin
               if (open_ff) begin
                  push     = 1'b1;
                  cmd.kind = CMD_DATA;
                  rem_in   = rem_ff - 16'd1;
                  if (rem_ff == 16'd1) begin
                     cmd.close = 1'b1;
                     wp_in     = wp_ff + 16'd3;
                     count_in  = count_next;
                     open_in   = 1'b0;
                  end else begin
                     wp_in = wp_ff + 16'd1;
                  end
               end
            end
            default: begin
               push = 1'b0;
            end
         endcase
      end
   end

endmodule

### sv/ptf_queue.sv
// ----------------------------------------------------------------------------
// ptf_queue
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module ptf_queue import ptf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    head_valid,
   output cmd_type head_cmd,
   output logic    full
);

   cmd_type             slot_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic                do_pop;

   assign full       = (cnt_ff == QCNT_W'(QDEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_cmd   = slot_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + QCNT_W'(push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### sv/ptf_back.sv
// ----------------------------------------------------------------------------
// ptf_back
// Expands each queued command into its buffer write results, one per cycle
// while rsp_stall is low, through a registered output stage.
// ----------------------------------------------------------------------------
module ptf_back import ptf_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            head_valid,
   input  cmd_type         head_cmd,
   input  logic [15:0]     packet_id,
   output logic            pop,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   logic [BEAT_W-1:0] beat_ff, beat_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_payload_ff, rsp_payload_in;

   logic              load;
   logic              fire;
   logic [CNT_W-1:0]  body_beats;
   logic [CNT_W-1:0]  raw_total;
   logic [CNT_W-1:0]  total;
   logic [CNT_W-1:0]  beat_wide;
   logic              is_last;
   logic              is_count;
   logic              is_tail;
   logic [63:0]       ttag_wide;
   logic [7:0]        hdr [2**BEAT_W];

   assign load      = !rsp_valid_ff || !rsp_stall;
   assign fire      = load && head_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   always_comb begin
      ttag_wide = {32'b0, head_cmd.ttag};
      for (int i = 0; i < 2**BEAT_W; i++) begin
         hdr[i] = '0;
      end
      hdr[0] = packet_id[15:8];
      hdr[1] = packet_id[7:0];
      hdr[2] = 8'h00;
      hdr[3] = head_cmd.seq;
      hdr[4] = head_cmd.coded[15:8];
      hdr[5] = head_cmd.coded[7:0];
      hdr[6] = VERSION_BYTE;
      hdr[7] = head_cmd.ptype;
      hdr[8] = head_cmd.psub;
      for (int i = 0; i < TIME_BYTES; i++) begin
         if (9 + i < 2**BEAT_W) begin
            hdr[9 + i] = ttag_wide[(TIME_BYTES - 1 - i) * 8 +: 8];
         end
      end
   end

   always_comb begin
      body_beats = (head_cmd.kind == CMD_HEADER) ? CNT_W'(HDR_BYTES) : CNT_W'(1);
      raw_total  = body_beats + (head_cmd.close ? CNT_W'(CLOSE_BEATS) : '0);
      total      = (raw_total > CNT_W'(MAX_RESULTS)) ? CNT_W'(MAX_RESULTS) : raw_total;
      beat_wide  = {1'b0, beat_ff};
      is_last    = (beat_wide == total - 1'b1);
      is_count   = head_cmd.close && (beat_wide == body_beats + CNT_W'(2));
      is_tail    = head_cmd.close && (beat_wide >= body_beats) && !is_count;

      rsp_payload_in.write_valid = (head_cmd.kind != CMD_OVERFLOW);
      rsp_payload_in.overflow    = (head_cmd.kind == CMD_OVERFLOW);
      rsp_payload_in.last        = is_last;

      if (is_count || head_cmd.kind == CMD_RESET || head_cmd.kind == CMD_OVERFLOW) begin
         rsp_payload_in.write_address = '0;
      end else begin
         rsp_payload_in.write_address = head_cmd.addr + 16'(beat_ff);
      end

      if (is_count) begin
         rsp_payload_in.write_byte = head_cmd.count;
      end else if (is_tail) begin
         rsp_payload_in.write_byte = '0;
      end else begin
         unique case (head_cmd.kind)
            CMD_HEADER: rsp_payload_in.write_byte = hdr[beat_ff];
            CMD_DATA:   rsp_payload_in.write_byte = head_cmd.pbyte;
            default:    rsp_payload_in.write_byte = '0;
         endcase
      end

      pop          = fire && is_last;
      beat_in      = fire ? (is_last ? '0 : beat_ff + 1'b1) : beat_ff;
      rsp_valid_in = load ? head_valid : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         beat_ff      <= beat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_overflow_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_payload_ff.overflow |->
         rsp_payload_ff.last && !rsp_payload_ff.write_valid)
      else $error("overflow result not a lone final result");

   a_beat_restart: assert property (@(posedge clock) disable iff (reset)
      fire && is_last |=> beat_ff == '0)
      else $error("beat counter did not restart after final result");

   a_beat_has_cmd: assert property (@(posedge clock) disable iff (reset)
      beat_ff != '0 |-> head_valid)
      else $error("beat counter running without a queued command");
`endif

endmodule

### tb/tb_pus_telemetry_packet_framer.sv
// ----------------------------------------------------------------------------
// tb_pus_telemetry_packet_framer
// Self-checking bench for the telemetry packet framer. Every accepted item
// runs through a local model of the framing state. The model queues the
// buffer writes the item should cause. Each write transfer on the result
// channel is checked in order against that queue. Directed tests cover
// headers, empty packets, abandoned and overflowing packets and capacity
// extremes. Random phases then send well-formed packet streams mixed with
// noise, with sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_pus_telemetry_packet_framer;
   import ptf_pkg::*;

   localparam logic [1:0] FUNC_UNUSED   = 2'd3;
   localparam logic [2:0] CAPACITY_ADDR = 3'd0;
   localparam logic [2:0] PACKET_ID_ADDR = 3'd4;
   localparam int         HOLD_CYCLES   = 60;
   localparam int         WATCHDOG_LIMIT = 4000;
   localparam int         REPORT_LIMIT  = 10;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;
   logic            psel = 1'b0;
   logic            penable = 1'b0;
   logic            pwrite = 1'b0;
   logic [2:0]      paddr = '0;
   logic [31:0]     pwdata = '0;
   logic [31:0]     prdata;
   logic            pready;

   // framing model state
   logic [15:0] capacity_reg = 16'd1024;
   logic [15:0] packet_id_reg = 16'd0;
   logic [15:0] frame_ptr = 16'd0;
   logic [7:0]  seq_count = 8'd192;
   logic [7:0]  packet_count = 8'd0;
   logic [15:0] bytes_left = 16'd0;
   logic        packet_open = 1'b0;

   rsp_payload_type item_writes [MAX_RESULTS];
   int              item_write_count;
   rsp_payload_type expected_writes [$];

   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int writing_items = 0;
   int fail_count = 0;
   int idle_cycles = 0;

   pus_telemetry_packet_framer DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #6 clock = ~clock;

   function automatic void add_write(input logic [15:0] addr, input logic [7:0] data,
                                     input logic valid, input logic ovf);
      if (item_write_count < MAX_RESULTS) begin
         item_writes[item_write_count].write_address = addr;
         item_writes[item_write_count].write_byte = data;
         item_writes[item_write_count].write_valid = valid;
         item_writes[item_write_count].overflow = ovf;
         item_writes[item_write_count].last = 1'b0;
         item_write_count++;
      end
   endfunction

   function automatic void put_byte(input logic [7:0] data);
      add_write(frame_ptr, data, 1'b1, 1'b0);
      frame_ptr = frame_ptr + 16'd1;
   endfunction

   function automatic void close_packet_writes();
      put_byte(8'd0);
      put_byte(8'd0);
      packet_count = packet_count + 8'd1;
      add_write(16'd0, packet_count, 1'b1, 1'b0);
      packet_open = 1'b0;
      bytes_left = 16'd0;
   endfunction

   task automatic predict_writes(input req_payload_type item);
      int unsigned need;
      logic [15:0] coded;
      int          sh;
      item_write_count = 0;
      case (item.func)
         FUNC_RESET: begin
            frame_ptr = 16'd1;
            packet_count = 8'd0;
            packet_open = 1'b0;
            bytes_left = 16'd0;
            add_write(16'd0, 8'd0, 1'b1, 1'b0);
         end
         FUNC_START: begin
            seq_count = (seq_count == SEQ_WRAP) ? SEQ_BASE : seq_count + 8'd1;
            packet_open = 1'b0;
            bytes_left = 16'd0;
            need = int'(frame_ptr) + int'(item.data_length) + FIT_EXTRA;
            if (need > int'(capacity_reg)) begin
               add_write(16'd0, 8'd0, 1'b0, 1'b1);
            end else begin
               coded = item.data_length + 16'(CODED_EXTRA);
               put_byte(packet_id_reg[15:8]);
               put_byte(packet_id_reg[7:0]);
               put_byte(8'd0);
               put_byte(seq_count);
               put_byte(coded[15:8]);
               put_byte(coded[7:0]);
               put_byte(VERSION_BYTE);
               put_byte(item.packet_type);
               put_byte(item.packet_subtype);
               for (int i = TIME_BYTES - 1; i >= 0; i--) begin
                  sh = i * 8;
                  put_byte((sh < 32) ? 8'(item.time_tag >> sh) : 8'd0);
               end
               if (item.data_length == 16'd0) begin
                  close_packet_writes();
               end else begin
                  packet_open = 1'b1;
                  bytes_left = item.data_length;
               end
            end
         end
         FUNC_DATA: begin
            if (packet_open) begin
               put_byte(item.payload_byte);
               bytes_left = bytes_left - 16'd1;
               if (bytes_left == 16'd0) close_packet_writes();
            end
         end
         default: ;
      endcase
      if (item_write_count > 0) begin
         item_writes[item_write_count - 1].last = 1'b1;
         writing_items++;
      end
      for (int i = 0; i < item_write_count; i++) expected_writes.push_back(item_writes[i]);
   endtask

   // called at a rising edge; leaves req_valid high after the transfer
   task automatic send_item(input req_payload_type item);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_writes(item);
   endtask

   task automatic drain_writes();
      req_valid <= 1'b0;
      while (expected_writes.size() != 0) @(posedge clock);
      repeat (HOLD_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic set_config(input logic [15:0] capacity, input logic [15:0] packet_id);
      drain_writes();
      csr_write(CAPACITY_ADDR, {16'd0, capacity});
      capacity_reg = capacity;
      csr_write(PACKET_ID_ADDR, {16'd0, packet_id});
      packet_id_reg = packet_id;
   endtask

   function automatic req_payload_type random_item(input logic [1:0] func);
      req_payload_type it;
      it.func = func;
      it.data_length = 16'($urandom);
      it.packet_type = 8'($urandom);
      it.packet_subtype = 8'($urandom);
      it.time_tag = $urandom;
      it.payload_byte = 8'($urandom);
      return it;
   endfunction

   function automatic req_payload_type start_item(input logic [15:0] len, input logic [7:0] ptype,
                                                  input logic [7:0] psub, input logic [31:0] ttag);
      req_payload_type it;
      it = random_item(FUNC_START);
      it.data_length = len;
      it.packet_type = ptype;
      it.packet_subtype = psub;
      it.time_tag = ttag;
      return it;
   endfunction

   function automatic req_payload_type data_item(input logic [7:0] data);
      req_payload_type it;
      it = random_item(FUNC_DATA);
      it.payload_byte = data;
      return it;
   endfunction

   task automatic test_start_before_reset();
      send_item(start_item(16'd0, 8'h5A, 8'hA5, 32'h1234_5678));
   endtask

   task automatic test_empty_packet();
      send_item(random_item(FUNC_RESET));
      send_item(start_item(16'd0, 8'hFF, 8'h00, 32'hFFFF_FFFF));
   endtask

   task automatic test_ignored_items();
      req_payload_type it;
      send_item(data_item(8'hFF));
      it = '1;
      it.func = FUNC_UNUSED;
      send_item(it);
   endtask

   task automatic test_payload_packet();
      send_item(start_item(16'd3, 8'h00, 8'hFF, 32'h0000_0000));
      send_item(data_item(8'h00));
      send_item(data_item(8'hFF));
      send_item(data_item(8'h5A));
   endtask

   task automatic test_abandoned_packet();
      send_item(start_item(16'd2, 8'h11, 8'h22, 32'hA5A5_5A5A));
      send_item(data_item(8'h7E));
      send_item(start_item(16'd1, 8'h33, 8'h44, 32'h0F0F_F0F0));
      send_item(data_item(8'h81));
   endtask

   task automatic test_capacity_limits();
      set_config(16'd1, 16'hFFFF);
      send_item(start_item(16'd0, 8'h01, 8'h02, 32'h8000_0001));
      set_config(16'hFFFF, 16'h0000);
      send_item(random_item(FUNC_RESET));
      send_item(start_item(16'hFFEF, 8'hC3, 8'h3C, 32'h0123_4567));
      send_item(data_item(8'hAA));
      send_item(data_item(8'h55));
      send_item(start_item(16'hFFFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF));
      send_item(random_item(FUNC_RESET));
      send_item(data_item(8'h01));
   endtask

   task automatic test_random_stream(input int idle_pct, input int stall_pct, input int budget,
                                     input logic [15:0] capacity, input logic [15:0] packet_id);
      int          start_count;
      int          choice;
      int          len;
      int          sent_bytes;
      req_payload_type it;
      set_config(capacity, packet_id);
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      start_count = writing_items;
      while (writing_items - start_count < budget) begin
         choice = $urandom_range(99);
         if (choice < 6 || (int'(frame_ptr) + 30 > int'(capacity_reg) && choice < 50)) begin
            send_item(random_item(FUNC_RESET));
         end else if (choice < 12) begin
            it = random_item($urandom_range(1) ? FUNC_UNUSED : FUNC_DATA);
            send_item(it);
         end else if (choice < 16) begin
            send_item(random_item(FUNC_START));
         end else begin
            choice = $urandom_range(99);
            if (choice < 25) len = 0;
            else if (choice < 90) len = $urandom_range(1, 5);
            else len = $urandom_range(6, 20);
            it = random_item(FUNC_START);
            it.data_length = 16'(len);
            send_item(it);
            sent_bytes = ($urandom_range(9) == 0) ? $urandom_range(len) : len;
            for (int i = 0; i < sent_bytes; i++) send_item(random_item(FUNC_DATA));
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   // check each write transfer against the oldest expectation
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_writes.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
               $display("unexpected write: addr %h byte %h valid %b ovf %b last %b",
                        rsp_payload.write_address, rsp_payload.write_byte,
                        rsp_payload.write_valid, rsp_payload.overflow, rsp_payload.last);
         end else begin
            want = expected_writes.pop_front();
            if (rsp_payload.write_address !== want.write_address ||
                rsp_payload.write_byte !== want.write_byte ||
                rsp_payload.write_valid !== want.write_valid ||
                rsp_payload.overflow !== want.overflow ||
                rsp_payload.last !== want.last) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("mismatch: expected addr %h byte %h valid %b ovf %b last %b, got addr %h byte %h valid %b ovf %b last %b",
                           want.write_address, want.write_byte, want.write_valid,
                           want.overflow, want.last,
                           rsp_payload.write_address, rsp_payload.write_byte,
                           rsp_payload.write_valid, rsp_payload.overflow, rsp_payload.last);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", idle_cycles);
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_start_before_reset();
      test_empty_packet();
      test_ignored_items();
      test_payload_packet();
      test_abandoned_packet();
      test_capacity_limits();
      test_random_stream(0, 0, 48, 16'd400, 16'h1234);
      test_random_stream(56, 0, 48, 16'hFFFF, 16'($urandom));
      test_random_stream(0, 56, 48, 16'($urandom_range(60, 600)), 16'hFFFF);
      test_random_stream(14, 14, 48, 16'd1024, 16'd0);
      drain_writes();
      if (expected_writes.size() != 0) begin
         fail_count++;
         $display("expected writes left over: %0d", expected_writes.size());
      end
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
